// File: rtl/core/jsme_pkg.sv
`default_nettype none

package jsme_pkg;

  // Table and field geometry
  localparam int unsigned MAX_JOBS      = 16;
  localparam int unsigned MAX_MACHINES  = 16;
  localparam int unsigned DURATION_BITS = 16;
  localparam int unsigned SLOTS         = 16;

  localparam int unsigned JOB_W   = 4;
  localparam int unsigned SLOT_W  = $clog2(SLOTS);
  localparam int unsigned MACH_W  = 4;
  localparam int unsigned DUR_W   = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned OP_W    = SLOT_W + 1;
  localparam int unsigned ADDR_W  = JOB_W + SLOT_W;
  localparam int unsigned TABLE_DEPTH = MAX_JOBS * SLOTS;

  // Command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_SCHED = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = CNT_W;
  localparam logic [CFG_IDX_W-1:0] CFG_JOB_COUNT     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MACHINE_COUNT = 1'b1;
  localparam logic [CNT_W-1:0]     COUNT_RESET       = CNT_W'(16);

  // Classified item passed from front to back
  typedef struct packed {
    logic                     sched;
    logic                     job_ok;
    logic [JOB_W-1:0]         job;
    logic [SLOT_W-1:0]        slot;
    logic [MACH_W-1:0]        machine;
    logic [DURATION_BITS-1:0] duration;
    logic                     last;
  } jsme_item_t;

  // One operation table entry
  typedef struct packed {
    logic [MACH_W-1:0]        machine;
    logic [DURATION_BITS-1:0] duration;
  } jsme_entry_t;

  // One result
  typedef struct packed {
    logic [JOB_W-1:0]  job;
    logic [SLOT_W-1:0] op_index;
    logic [MACH_W-1:0] machine;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] makespan;
    logic              error;
    logic              last;
  } jsme_result_t;

endpackage

`default_nettype wire

// File: rtl/core/job_shop_makespan_evaluator.sv
// Job-shop schedule decoder with running makespan.
// Input channel (in_valid_i/in_ready_o): cmd_i = 0 loads one table entry
// (job, op_slot, machine, duration); cmd_i = 1 schedules the next operation
// of job_i. Loads give no result; each schedule item gives exactly one.
// Output channel (out_valid_o/out_ready_i): job, operation index, machine,
// start, saturating finish, running makespan, error and the echoed last flag.
// Configuration channel (cfg_valid_i/cfg_ready_o, always ready): index 0 is
// job_count, index 1 is machine_count; write only while the block is idle.
// Throughput: one item per cycle, loads and schedules alike, while the output
// is not stalled. A result passes the input register, two-entry queue, table
// read, then the execute stage that reads the ready times and writes the
// output register. A schedule and its successor share no stall because ready
// times and slot counters update in the stage that reads them.
// When the receiver stalls, the output register holds, the execute stage and
// queue fill, and in_ready_o falls once the input register cannot drain.
// Reset clears all table valid bits, slot counters, ready times, makespan and
// sets both counts to 16; a last flag on a schedule clears run state, not the table.
`default_nettype none

module job_shop_makespan_evaluator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [jsme_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [jsme_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            cmd_i,
  input  logic [jsme_pkg::JOB_W-1:0]      job_i,
  input  logic [jsme_pkg::SLOT_W-1:0]     op_slot_i,
  input  logic [jsme_pkg::MACH_W-1:0]     machine_i,
  input  logic [jsme_pkg::DUR_W-1:0]      duration_i,
  input  logic                            last_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [jsme_pkg::JOB_W-1:0]      job_out_o,
  output logic [jsme_pkg::SLOT_W-1:0]     op_index_o,
  output logic [jsme_pkg::MACH_W-1:0]     machine_out_o,
  output logic [jsme_pkg::TIME_W-1:0]     start_time_o,
  output logic [jsme_pkg::TIME_W-1:0]     finish_time_o,
  output logic [jsme_pkg::TIME_W-1:0]     makespan_o,
  output logic                            error_o,
  output logic                            last_out_o
);
  import jsme_pkg::*;

  logic         f_valid, f_ready, q_valid, q_ready;
  jsme_item_t   f_item, q_item;
  jsme_result_t result;

  // Front: configuration and classification
  jsme_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .job_i        (job_i),
    .op_slot_i    (op_slot_i),
    .machine_i    (machine_i),
    .duration_i   (duration_i),
    .last_i       (last_i),
    .item_valid_o (f_valid),
    .item_o       (f_item),
    .item_ready_i (f_ready)
  );

  // Decoupling queue
  jsme_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_item_o   (q_item)
  );

  // Back: table, run state, result
  jsme_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (q_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (result)
  );

  assign job_out_o     = result.job;
  assign op_index_o    = result.op_index;
  assign machine_out_o = result.machine;
  assign start_time_o  = result.start_time;
  assign finish_time_o = result.finish_time;
  assign makespan_o    = result.makespan;
  assign error_o       = result.error;
  assign last_out_o    = result.last;

endmodule

`default_nettype wire

// File: rtl/core/jsme_front.sv
`default_nettype none

module jsme_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [jsme_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [jsme_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             cmd_i,
  input  logic [jsme_pkg::JOB_W-1:0]       job_i,
  input  logic [jsme_pkg::SLOT_W-1:0]      op_slot_i,
  input  logic [jsme_pkg::MACH_W-1:0]      machine_i,
  input  logic [jsme_pkg::DUR_W-1:0]       duration_i,
  input  logic                             last_i,
  output logic                             item_valid_o,
  output jsme_pkg::jsme_item_t             item_o,
  input  logic                             item_ready_i
);
  import jsme_pkg::*;

  logic [CNT_W-1:0] job_count_q, machine_count_q;
  logic             valid_q, valid_d;
  jsme_item_t       item_q, item_d;
  logic             accept, keep, job_in_table, mach_ok;

  // Configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_count_q     <= COUNT_RESET;
      machine_count_q <= COUNT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_JOB_COUNT:     job_count_q     <= cfg_data_i;
        CFG_MACHINE_COUNT: machine_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Classify the incoming item
  always_comb begin
    job_in_table    = 32'(job_i) < MAX_JOBS;
    mach_ok         = (CNT_W'(machine_i) < machine_count_q) && (32'(machine_i) < MAX_MACHINES);
    item_d.sched    = (cmd_i == CMD_SCHED);
    item_d.job_ok   = job_in_table && (CNT_W'(job_i) < job_count_q);
    item_d.job      = job_i;
    item_d.slot     = op_slot_i;
    item_d.machine  = machine_i;
    item_d.duration = duration_i[DURATION_BITS-1:0];
    item_d.last     = last_i;
    // drop loads that name a job outside the table or a machine beyond machine_count
    keep            = item_d.sched || (job_in_table && mach_ok);
  end

  assign in_ready_o = !valid_q || item_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Hold the classified item until the queue takes it
  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = keep;
    end else if (item_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

// File: rtl/core/jsme_queue.sv
`default_nettype none

module jsme_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  jsme_pkg::jsme_item_t push_item_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output jsme_pkg::jsme_item_t pop_item_o
);
  import jsme_pkg::*;

  jsme_item_t  slot_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q, count_d;
  logic        push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = slot_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/jsme_back.sv
`default_nettype none

module jsme_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   item_valid_i,
  output logic                   item_ready_o,
  input  jsme_pkg::jsme_item_t   item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output jsme_pkg::jsme_result_t result_o
);
  import jsme_pkg::*;

  // Operation table: data in memory, valid bits in flops
  jsme_entry_t       table_mem [TABLE_DEPTH];
  logic              valid_q   [TABLE_DEPTH];
  jsme_entry_t       rd_q;

  // Run state
  logic [OP_W-1:0]   next_op_q       [MAX_JOBS];
  logic [TIME_W-1:0] job_ready_q     [MAX_JOBS];
  logic [TIME_W-1:0] machine_ready_q [MAX_MACHINES];
  logic [TIME_W-1:0] makespan_q;

  // Execute stage
  logic              s2_valid_q, s2_ok_q, s2_last_q;
  logic [JOB_W-1:0]  s2_job_q;
  logic [SLOT_W-1:0] s2_op_q;

  logic              out_valid_q;
  jsme_result_t      res_q;

  logic              s2_fire, issue_ready, issue, do_load, do_sched, entry_ok;
  logic [OP_W-1:0]   cur_op;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [MACH_W-1:0] m;
  logic [TIME_W-1:0] jr, mr, start, finish, span_new;
  logic [TIME_W:0]   sum;

  // Issue: loads retire here, schedules read the table
  assign s2_fire      = s2_valid_q && (!out_valid_q || out_ready_i);
  assign issue_ready  = !item_i.sched || !s2_valid_q || s2_fire;
  assign item_ready_o = issue_ready;
  assign issue        = item_valid_i && issue_ready;
  assign do_load      = issue && !item_i.sched;
  assign do_sched     = issue && item_i.sched;

  assign cur_op   = next_op_q[item_i.job];
  assign rd_addr  = {item_i.job, cur_op[SLOT_W-1:0]};
  assign wr_addr  = {item_i.job, item_i.slot};
  assign entry_ok = item_i.job_ok && !cur_op[SLOT_W] && valid_q[rd_addr];

  // Advance the job's slot counter; clear all at end of sequence
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_JOBS; j++) next_op_q[j] <= '0;
    end else if (do_sched) begin
      if (item_i.last) begin
        for (int j = 0; j < MAX_JOBS; j++) next_op_q[j] <= '0;
      end else if (entry_ok) begin
        next_op_q[item_i.job] <= cur_op + OP_W'(1);
      end
    end
  end

  // Mark loaded entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TABLE_DEPTH; k++) valid_q[k] <= 1'b0;
    end else if (do_load) begin
      valid_q[wr_addr] <= 1'b1;
    end
  end

  // Table write and registered read
  always_ff @(posedge clk_i) begin
    if (do_load) begin
      table_mem[wr_addr] <= {item_i.machine, item_i.duration};
    end
    if (do_sched) begin
      rd_q <= table_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (do_sched) begin
      s2_valid_q <= 1'b1;
    end else if (s2_fire) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_sched) begin
      s2_ok_q   <= entry_ok;
      s2_job_q  <= item_i.job;
      s2_op_q   <= item_i.job_ok ? cur_op[SLOT_W-1:0] : '0;
      s2_last_q <= item_i.last;
    end
  end

  // Execute: start, saturating finish, running makespan
  always_comb begin
    m        = rd_q.machine;
    jr       = job_ready_q[s2_job_q];
    mr       = machine_ready_q[m];
    start    = (jr > mr) ? jr : mr;
    sum      = {1'b0, start} + (TIME_W+1)'(rd_q.duration);
    finish   = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    span_new = (finish > makespan_q) ? finish : makespan_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_JOBS; j++)     job_ready_q[j]     <= '0;
      for (int k = 0; k < MAX_MACHINES; k++) machine_ready_q[k] <= '0;
      makespan_q <= '0;
    end else if (s2_fire) begin
      if (s2_last_q) begin
        for (int j = 0; j < MAX_JOBS; j++)     job_ready_q[j]     <= '0;
        for (int k = 0; k < MAX_MACHINES; k++) machine_ready_q[k] <= '0;
        makespan_q <= '0;
      end else if (s2_ok_q) begin
        job_ready_q[s2_job_q] <= finish;
        machine_ready_q[m]    <= finish;
        makespan_q            <= span_new;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      res_q.job         <= s2_job_q;
      res_q.op_index    <= s2_op_q;
      res_q.machine     <= s2_ok_q ? m : '0;
      res_q.start_time  <= s2_ok_q ? start : '0;
      res_q.finish_time <= s2_ok_q ? finish : '0;
      res_q.makespan    <= s2_ok_q ? span_new : makespan_q;
      res_q.error       <= !s2_ok_q;
      res_q.last        <= s2_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule

`default_nettype wire

// File: rtl/core/jsme_checker.sv
`default_nettype none

module jsme_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [jsme_pkg::JOB_W-1:0]      job_out_o,
  input logic [jsme_pkg::MACH_W-1:0]     machine_out_o,
  input logic [jsme_pkg::TIME_W-1:0]     start_time_o,
  input logic [jsme_pkg::TIME_W-1:0]     finish_time_o,
  input logic [jsme_pkg::TIME_W-1:0]     makespan_o,
  input logic                            error_o
);
  import jsme_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(job_out_o)
      && $stable(makespan_o) && $stable(finish_time_o))
    else $error("stalled result changed");

  // A flagged result carries no timing
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> machine_out_o == '0 && start_time_o == '0
      && finish_time_o == '0)
    else $error("error result with nonzero timing");

  // Finish follows start and makespan covers finish
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !error_o |-> finish_time_o >= start_time_o
      && makespan_o >= finish_time_o)
    else $error("time order broken");

  // No result straight out of reset
  a_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid after reset");

endmodule

bind job_shop_makespan_evaluator jsme_checker u_jsme_checker (.*);

`default_nettype wire
